// ===== src/pfd_pkg.sv =====
// pfd_pkg: widths, register indexes and saturation helpers for the pid unit
// no dependencies; used by the interfaces, the serial units and the top level

package pfd_pkg;

    // Q16.16 word format
    localparam int DW = 32;
    localparam int FB = 16;
    localparam int PW = 2 * DW;
    // magnitude width of the filter numerator fed to the divider
    localparam int NW = 2 * (DW - FB) + FB + 1;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SETPOINT = 3'd0,
        CFG_GAIN_P   = 3'd1,
        CFG_GAIN_I   = 3'd2,
        CFG_GAIN_D   = 3'd3,
        CFG_TAU      = 3'd4,
        CFG_PERIOD   = 3'd5,
        CFG_OUT_MIN  = 3'd6,
        CFG_OUT_MAX  = 3'd7
    } t_cfg_idx;

    localparam logic signed [DW-1:0] WORD_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] WORD_MIN = {1'b1, {(DW-1){1'b0}}};

    // clamp a 64-bit value to the word range
    function automatic logic signed [DW-1:0] sat64(input logic signed [PW-1:0] v);
        logic signed [DW-1:0] res;
        if (v > PW'(WORD_MAX)) begin
            res = WORD_MAX;
        end else if (v < PW'(WORD_MIN)) begin
            res = WORD_MIN;
        end else begin
            res = v[DW-1:0];
        end
        return res;
    endfunction

    // clamp a word-plus-two-bit sum to the word range
    function automatic logic signed [DW-1:0] sat34(input logic signed [DW+1:0] v);
        logic signed [DW-1:0] res;
        if (v > (DW+2)'(WORD_MAX)) begin
            res = WORD_MAX;
        end else if (v < (DW+2)'(WORD_MIN)) begin
            res = WORD_MIN;
        end else begin
            res = v[DW-1:0];
        end
        return res;
    endfunction

    // drop the fraction of a product, rounding half up
    function automatic logic signed [PW-1:0] rnd64(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] half;
        half = PW'(64'sd1 <<< (FB - 1));
        return (v + half) >>> FB;
    endfunction

endpackage

// ===== src/pfd_ifs.sv =====
// pfd_in_if / pfd_out_if: valid-ready channels for measurement and drive words
// depends on pfd_pkg for the word width

interface pfd_in_if;
    logic                          valid;
    logic                          ready;
    logic signed [pfd_pkg::DW-1:0] measured;
    modport source (output valid, output measured, input ready);
    modport sink   (input valid, input measured, output ready);
endinterface

interface pfd_out_if;
    logic                          valid;
    logic                          ready;
    logic signed [pfd_pkg::DW-1:0] drive;
    logic                          saturated;
    modport source (output valid, output drive, output saturated, input ready);
    modport sink   (input valid, input drive, input saturated, output ready);
endinterface

// ===== src/pfd_mul.sv =====
// pfd_mul: signed word by word multiplier, one multiplier bit per cycle
// depends on pfd_pkg for widths

module pfd_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [pfd_pkg::DW-1:0] i_a,
    input  logic signed [pfd_pkg::DW-1:0] i_b,
    output logic                          o_done,
    output logic signed [pfd_pkg::PW-1:0] o_prod
);
    localparam int DW = pfd_pkg::DW;
    localparam int CW = $clog2(DW);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic signed [DW-1:0] r_a, n_a;
    logic signed [DW:0]   r_hi, n_hi;
    logic [DW-1:0]        r_lo, n_lo;
    logic signed [DW+1:0] w_add, w_sum;

    // add or, for the sign bit, subtract the multiplicand, then shift right
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_hi   = r_hi;
        n_lo   = r_lo;
        w_add  = '0;
        if (r_lo[0]) begin
            if (r_cnt == CW'(DW - 1)) begin
                w_add = -(DW+2)'(r_a);
            end else begin
                w_add = (DW+2)'(r_a);
            end
        end
        w_sum = (DW+2)'(r_hi) + w_add;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_a    = i_a;
            n_hi   = '0;
            n_lo   = i_b;
        end else if (r_busy) begin
            n_hi  = w_sum[DW+1:1];
            n_lo  = {w_sum[0], r_lo[DW-1:1]};
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == CW'(DW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_a  <= n_a;
        r_hi <= n_hi;
        r_lo <= n_lo;
    end

    assign o_done = r_done;
    assign o_prod = {r_hi[DW-1:0], r_lo};
endmodule

// ===== src/pfd_div.sv =====
// pfd_div: restoring divider for the derivative filter, one quotient bit per cycle
// depends on pfd_pkg for widths

module pfd_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pfd_pkg::NW-1:0]     i_mag,
    input  logic [pfd_pkg::DW:0]       i_den,
    output logic                       o_done,
    output logic [pfd_pkg::DW:0]       o_quo,
    output logic                       o_ovf
);
    localparam int DW = pfd_pkg::DW;
    localparam int FB = pfd_pkg::FB;
    localparam int NW = pfd_pkg::NW;
    localparam int LW = NW + FB;
    localparam int CW = $clog2(LW);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [LW-1:0] r_n, n_n;
    logic [DW:0]   r_rem, n_rem;
    logic [DW:0]   r_den, n_den;
    logic [DW:0]   r_q, n_q;
    logic [DW+1:0] w_trial;

    // shift one dividend bit into the remainder and try the subtract
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_ovf   = r_ovf;
        n_cnt   = r_cnt;
        n_n     = r_n;
        n_rem   = r_rem;
        n_den   = r_den;
        n_q     = r_q;
        w_trial = {r_rem, r_n[LW-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_ovf  = 1'b0;
            n_cnt  = '0;
            n_n    = {i_mag, {FB{1'b0}}};
            n_rem  = '0;
            n_den  = i_den;
            n_q    = '0;
        end else if (r_busy) begin
            n_n   = {r_n[LW-2:0], 1'b0};
            n_ovf = r_ovf | r_q[DW];
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = (DW+1)'(w_trial - {1'b0, r_den});
                n_q   = {r_q[DW-1:0], 1'b1};
            end else begin
                n_rem = w_trial[DW:0];
                n_q   = {r_q[DW-1:0], 1'b0};
            end
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == CW'(LW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_ovf <= n_ovf;
        r_n   <= n_n;
        r_rem <= n_rem;
        r_den <= n_den;
        r_q   <= n_q;
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_ovf  = r_ovf;
endmodule

// ===== src/pid_filtered_derivative_unit.sv =====
// pid_filtered_derivative_unit: Q16.16 pid controller with filtered derivative
// depends on pfd_pkg, pfd_ifs, pfd_mul and pfd_div

// Usage:
// Write the eight registers through i_cfg_we / i_cfg_idx / i_cfg_data while
// the unit is idle. Each measurement word offered on i_in yields one drive
// word on o_out, with saturated set when the drive hit out_min or out_max.
// Only one measurement is in flight: i_in.ready is high while idle.
// From acceptance to o_out.valid the unit runs six products on the
// bit-serial multiplier (each with start and post steps), one restoring
// division for the filter (skipped when tau and period are both zero), and
// four further steps (clamp, divider start, sum, output load). A new
// measurement is taken only after the output load returns the unit to idle.
// A finished word sits in the output register until o_out.ready; if the
// receiver stalls longer, the next result waits in the final step and no
// new measurement is taken.
// Reset (synchronous, active low) clears the integrator, the previous error
// and the filter state, and loads the register defaults: gains, setpoint
// and tau zero, period 1.0, limits at the full word range.

module pid_filtered_derivative_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pfd_in_if.sink                        i_in,
    pfd_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_idx,
    input  logic [pfd_pkg::DW-1:0]        i_cfg_data
);
    localparam int DW = pfd_pkg::DW;
    localparam int FB = pfd_pkg::FB;
    localparam int PW = pfd_pkg::PW;
    localparam int NW = pfd_pkg::NW;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_MSTART = 9'b000000010,
        S_MWAIT  = 9'b000000100,
        S_POST   = 9'b000001000,
        S_CLAMP  = 9'b000010000,
        S_DSTART = 9'b000100000,
        S_DWAIT  = 9'b001000000,
        S_SUM    = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    typedef enum logic [2:0] {
        OP_PROP  = 3'd0,
        OP_COEF  = 3'd1,
        OP_INTEG = 3'd2,
        OP_DGAIN = 3'd3,
        OP_DTAU  = 3'd4,
        OP_DPER  = 3'd5
    } t_op;

    t_state r_state;
    t_op    r_op;

    // configuration registers
    logic signed [DW-1:0] r_setpoint, r_gain_p, r_gain_i, r_gain_d;
    logic signed [DW-1:0] r_out_min, r_out_max;
    logic [DW-2:0]        r_tau, r_period;

    // loop state and working values
    logic signed [DW-1:0] r_acc, r_last, r_dfilt;
    logic signed [DW-1:0] r_err, r_prop, r_coef, r_integ, r_deriv;
    logic signed [PW-1:0] r_num;
    logic                 r_ov;
    logic signed [DW-1:0] r_drive;
    logic                 r_satf;

    logic                 w_accept;
    logic                 w_mstart, w_dstart;
    logic signed [DW-1:0] w_ma, w_mb;
    logic                 w_mdone, w_ddone, w_dovf;
    logic signed [PW-1:0] w_prod, w_rp;
    logic [DW:0]          w_quo, w_den;
    logic signed [DW-1:0] w_esum, w_ediff, w_hi, w_lo;
    logic signed [PW-1:0] w_mag64;
    logic signed [DW+1:0] w_total;
    logic signed [DW-1:0] w_total_sat;

    assign w_accept    = i_in.valid & i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_esum      = pfd_pkg::sat34((DW+2)'(r_err) + (DW+2)'(r_last));
    assign w_ediff     = pfd_pkg::sat34((DW+2)'(r_err) - (DW+2)'(r_last));
    assign w_rp        = pfd_pkg::rnd64(w_prod);
    assign w_den       = {1'b0, r_tau, 1'b0} + {2'b0, r_period};
    assign w_mag64     = r_num[PW-1] ? -r_num : r_num;
    assign w_mstart    = (r_state == S_MSTART);
    assign w_dstart    = (r_state == S_DSTART) && (w_den != '0);
    assign w_total     = (DW+2)'(r_prop) + (DW+2)'(r_integ) + (DW+2)'(r_deriv);
    assign w_total_sat = pfd_pkg::sat34(w_total);

    // anti-windup limits from the output limits less the proportional term
    always_comb begin
        if (r_out_max > r_prop) begin
            w_hi = pfd_pkg::sat34((DW+2)'(r_out_max) - (DW+2)'(r_prop));
        end else begin
            w_hi = '0;
        end
        if (r_out_min < r_prop) begin
            w_lo = pfd_pkg::sat34((DW+2)'(r_out_min) - (DW+2)'(r_prop));
        end else begin
            w_lo = '0;
        end
    end

    // multiplier operand select
    always_comb begin
        case (r_op)
            OP_PROP: begin
                w_ma = r_gain_p;
                w_mb = r_err;
            end
            OP_COEF: begin
                w_ma = r_gain_i;
                w_mb = {1'b0, r_period};
            end
            OP_INTEG: begin
                w_ma = r_coef;
                w_mb = w_esum;
            end
            OP_DGAIN: begin
                w_ma = r_gain_d;
                w_mb = w_ediff;
            end
            OP_DTAU: begin
                w_ma = {1'b0, r_tau};
                w_mb = r_dfilt;
            end
            OP_DPER: begin
                w_ma = {1'b0, r_period};
                w_mb = r_dfilt;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    pfd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mstart),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mdone),
        .o_prod  (w_prod)
    );

    pfd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_mag   (w_mag64[NW-1:0]),
        .i_den   (w_den),
        .o_done  (w_ddone),
        .o_quo   (w_quo),
        .o_ovf   (w_dovf)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= '0;
            r_gain_p   <= '0;
            r_gain_i   <= '0;
            r_gain_d   <= '0;
            r_tau      <= '0;
            r_period   <= (DW-1)'(1 << FB);
            r_out_min  <= pfd_pkg::WORD_MIN;
            r_out_max  <= pfd_pkg::WORD_MAX;
        end else if (i_cfg_we) begin
            case (pfd_pkg::t_cfg_idx'(i_cfg_idx))
                pfd_pkg::CFG_SETPOINT: r_setpoint <= i_cfg_data;
                pfd_pkg::CFG_GAIN_P:   r_gain_p   <= i_cfg_data;
                pfd_pkg::CFG_GAIN_I:   r_gain_i   <= i_cfg_data;
                pfd_pkg::CFG_GAIN_D:   r_gain_d   <= i_cfg_data;
                pfd_pkg::CFG_TAU:      r_tau      <= i_cfg_data[DW-2:0];
                pfd_pkg::CFG_PERIOD:   r_period   <= i_cfg_data[DW-2:0];
                pfd_pkg::CFG_OUT_MIN:  r_out_min  <= i_cfg_data;
                pfd_pkg::CFG_OUT_MAX:  r_out_max  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_PROP;
            r_acc   <= '0;
            r_last  <= '0;
            r_dfilt <= '0;
            r_ov    <= 1'b0;
        end else begin
            // output word valid: set when the final step loads it, cleared on handshake
            if (r_state == S_DONE && (!r_ov || o_out.ready)) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_err   <= pfd_pkg::sat34((DW+2)'(r_setpoint)
                                                  - (DW+2)'(i_in.measured));
                        r_op    <= OP_PROP;
                        r_state <= S_MSTART;
                    end
                end
                S_MSTART: begin
                    r_state <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (w_mdone) begin
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    r_state <= S_MSTART;
                    case (r_op)
                        OP_PROP: begin
                            r_prop <= pfd_pkg::sat64(w_rp);
                            r_op   <= OP_COEF;
                        end
                        OP_COEF: begin
                            r_coef <= pfd_pkg::sat64((w_prod + PW'(64'sd1 <<< FB))
                                                     >>> (FB + 1));
                            r_op   <= OP_INTEG;
                        end
                        OP_INTEG: begin
                            r_integ <= pfd_pkg::sat64(PW'(r_acc) + w_rp);
                            r_op    <= OP_DGAIN;
                            r_state <= S_CLAMP;
                        end
                        OP_DGAIN: begin
                            r_num <= w_rp <<< 1;
                            r_op  <= OP_DTAU;
                        end
                        OP_DTAU: begin
                            r_num <= r_num + (w_rp <<< 1);
                            r_op  <= OP_DPER;
                        end
                        OP_DPER: begin
                            r_num   <= r_num - w_rp;
                            r_state <= S_DSTART;
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_CLAMP: begin
                    if (r_integ > w_hi) begin
                        r_integ <= w_hi;
                        r_acc   <= w_hi;
                    end else if (r_integ < w_lo) begin
                        r_integ <= w_lo;
                        r_acc   <= w_lo;
                    end else begin
                        r_acc   <= r_integ;
                    end
                    r_state <= S_MSTART;
                end
                S_DSTART: begin
                    if (w_den == '0) begin
                        r_deriv <= '0;
                        r_state <= S_SUM;
                    end else begin
                        r_state <= S_DWAIT;
                    end
                end
                S_DWAIT: begin
                    if (w_ddone) begin
                        if (!r_num[PW-1]) begin
                            if (w_dovf | w_quo[DW] | w_quo[DW-1]) begin
                                r_deriv <= pfd_pkg::WORD_MAX;
                            end else begin
                                r_deriv <= w_quo[DW-1:0];
                            end
                        end else begin
                            if (w_dovf | w_quo[DW] | (w_quo[DW-1] & (|w_quo[DW-2:0])))
                            begin
                                r_deriv <= pfd_pkg::WORD_MIN;
                            end else begin
                                r_deriv <= -w_quo[DW-1:0];
                            end
                        end
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_dfilt <= r_deriv;
                    r_last  <= r_err;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // load the output register once the previous word has left
                    if (!r_ov || o_out.ready) begin
                        if (w_total_sat > r_out_max) begin
                            r_drive <= r_out_max;
                            r_satf  <= 1'b1;
                        end else if (w_total_sat < r_out_min) begin
                            r_drive <= r_out_min;
                            r_satf  <= 1'b1;
                        end else begin
                            r_drive <= w_total_sat;
                            r_satf  <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.drive     = r_drive;
    assign o_out.saturated = r_satf;

`ifndef SYNTH
    a_mul_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mdone |-> r_state == S_MWAIT)
        else $error("multiplier finished outside its wait step");
    a_div_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ddone |-> r_state == S_DWAIT)
        else $error("divider finished outside its wait step");
    a_accept_starts_prop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_MSTART && r_op == OP_PROP))
        else $error("accepted word did not start the proportional product");
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_satf) |-> (r_drive == r_out_max || r_drive == r_out_min))
        else $error("saturated flag set with drive away from the limits");
`endif
endmodule
